FILE: design/ncrc_pkg.sv
// Shared constants, types and helper functions of the NMEA / CRC-32 line checker.
package ncrc_pkg;

   // line scanning
   localparam int unsigned POS_W      = 10;
   localparam logic [POS_W-1:0] SCAN_LIMIT = POS_W'(512);
   localparam logic [POS_W-1:0] POS_MAX    = {POS_W{1'b1}};

   // characters
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_HASH   = 8'h23;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;

   // reflected CRC-32 polynomial
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;

   // number of hex digits in each trailer
   localparam logic [3:0] NMEA_DIGITS = 4'd2;
   localparam logic [3:0] CRC_DIGITS  = 4'd8;

   // register port
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic CSR_IDX_CRC_ENABLE = 1'b0;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_START = 2'd1,
      STATUS_NO_STAR   = 2'd2,
      STATUS_MISMATCH  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      KIND_UNKNOWN = 2'd0,
      KIND_NMEA    = 2'd1,
      KIND_CRC     = 2'd2
   } kind_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_item_type;

   typedef struct packed {
      status_type  status;
      kind_type    sentence_kind;
      logic [31:0] computed_check;
   } rsp_item_type;

   // One byte through the reflected CRC-32, bit by bit.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // Hex digit of either case: bit 4 marks a valid digit, bits 3:0 its value.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   // Lowercase hex character of one nibble.
   function automatic logic [7:0] hex_char_lower(input logic [3:0] nib);
      logic [7:0] r;
      if (nib < 4'd10) begin
         r = 8'h30 + {4'd0, nib};
      end else begin
         r = 8'h57 + {4'd0, nib};
      end
      return r;
   endfunction

endpackage

FILE: design/ncrc_req_if.sv
// Input channel: one line character per transaction.
interface ncrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       last;

   modport source (output valid, output ch, output last, input ready);
   modport sink   (input valid, input ch, input last, output ready);
endinterface

FILE: design/ncrc_rsp_if.sv
// Result channel: one line status per transaction.
interface ncrc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [1:0]  sentence_kind;
   logic [31:0] computed_check;

   modport source (output valid, output status, output sentence_kind,
                   output computed_check, input ready);
   modport sink   (input valid, input status, input sentence_kind,
                   input computed_check, output ready);
endinterface

FILE: design/ncrc_csr.sv
// APB-style register block holding the CRC check enable.
module ncrc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ncrc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ncrc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ncrc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output logic                             crc_check_enable
);
   import ncrc_pkg::*;

   logic crc_enable_ff;
   logic crc_enable_in;
   logic hit_enable;
   logic wr_strobe;

   // decode by word index; byte lanes within the word are ignored
   assign hit_enable = (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_CRC_ENABLE);
   assign wr_strobe  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      crc_enable_in = crc_enable_ff;
      if (wr_strobe && hit_enable) begin
         crc_enable_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_enable_ff <= 1'b0;
      end else begin
         crc_enable_ff <= crc_enable_in;
      end
   end

   // read back
   assign csr_prdata       = hit_enable ? {{(CSR_DATA_W-1){1'b0}}, crc_enable_ff}
                                        : '0;
   assign csr_pready       = 1'b1;
   assign crc_check_enable = crc_enable_ff;
endmodule

FILE: design/ncrc_in_stage.sv
// Input register: captures one character transaction and holds it until the engine takes it.
module ncrc_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  ncrc_pkg::req_item_type in_item,
   output logic                  stage_valid,
   output ncrc_pkg::req_item_type stage_item,
   input  logic                  stage_take
);
   import ncrc_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   // accept whenever the register is empty or drains this cycle
   assign in_ready = !valid_ff || stage_take;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload: load on accept only
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_item  = item_ff;
endmodule

FILE: design/ncrc_line_engine.sv
// Line state machine: XOR / CRC-32 update per character and the result register.
module ncrc_line_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   stage_valid,
   input  ncrc_pkg::req_item_type stage_item,
   output logic                   stage_take,
   input  logic                   crc_check_enable,
   output logic                   out_valid,
   output ncrc_pkg::rsp_item_type out_item,
   input  logic                   out_ready
);
   import ncrc_pkg::*;

   typedef enum logic [2:0] {
      PH_START,
      PH_NMEA_BODY,
      PH_NMEA_HEX,
      PH_CRC_BODY,
      PH_CRC_TEXT,
      PH_TAIL
   } phase_type;

   phase_type    phase_ff,  phase_in;
   kind_type     kind_ff,   kind_in;
   logic [7:0]   xor_ff,    xor_in;
   logic [31:0]  crc_ff,    crc_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]   hex_ff,    hex_in;
   logic [3:0]   dcnt_ff,   dcnt_in;
   status_type   err_ff,    err_in;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff,  out_item_in;

   logic         out_free;

   // a character without a result never waits; a final one waits for a free slot
   assign out_free   = !out_valid_ff || out_ready;
   assign stage_take = stage_valid && (!stage_item.last || out_free);

   // next state and result for the character in the input register
   always_comb begin
      logic [7:0]  c;
      logic [4:0]  hd;
      logic [4:0]  shamt;
      logic [3:0]  nib;
      status_type  st;
      logic [31:0] chk;

      c     = stage_item.ch;
      hd    = hex_digit(c);
      shamt = {~dcnt_ff[2:0], 2'b00};
      nib   = 4'(crc_ff >> shamt);
      st    = STATUS_OK;
      chk   = 32'd0;

      phase_in = phase_ff;
      kind_in  = kind_ff;
      xor_in   = xor_ff;
      crc_in   = crc_ff;
      pos_in   = pos_ff;
      hex_in   = hex_ff;
      dcnt_in  = dcnt_ff;
      err_in   = err_ff;

      case (phase_ff)
         PH_START: begin
            if (c == CHAR_DOLLAR) begin
               kind_in  = KIND_NMEA;
               phase_in = PH_NMEA_BODY;
            end else if (c == CHAR_HASH) begin
               kind_in  = KIND_CRC;
               phase_in = PH_CRC_BODY;
            end else begin
               kind_in  = KIND_UNKNOWN;
               err_in   = STATUS_BAD_START;
               phase_in = PH_TAIL;
            end
         end
         PH_NMEA_BODY: begin
            if (c == CHAR_STAR) begin
               phase_in = PH_NMEA_HEX;
               hex_in   = 8'd0;
               dcnt_in  = 4'd0;
            end else if (pos_ff >= SCAN_LIMIT) begin
               err_in   = STATUS_NO_STAR;
               phase_in = PH_TAIL;
            end else begin
               xor_in = xor_ff ^ c;
            end
         end
         PH_NMEA_HEX: begin
            if (!hd[4]) begin
               err_in   = (xor_ff != hex_ff) ? STATUS_MISMATCH : STATUS_OK;
               phase_in = PH_TAIL;
            end else begin
               hex_in  = {hex_ff[3:0], hd[3:0]};
               dcnt_in = dcnt_ff + 4'd1;
               if (dcnt_in >= NMEA_DIGITS) begin
                  err_in   = (xor_ff != hex_in) ? STATUS_MISMATCH : STATUS_OK;
                  phase_in = PH_TAIL;
               end
            end
         end
         PH_CRC_BODY: begin
            if (c == CHAR_STAR) begin
               phase_in = PH_CRC_TEXT;
               dcnt_in  = 4'd0;
               err_in   = STATUS_OK;
            end else begin
               crc_in = crc_byte(crc_ff, c);
            end
         end
         PH_CRC_TEXT: begin
            if (c != hex_char_lower(nib)) begin
               err_in = STATUS_MISMATCH;
            end
            dcnt_in = dcnt_ff + 4'd1;
            if (dcnt_in >= CRC_DIGITS) begin
               phase_in = PH_TAIL;
            end
         end
         default: begin
         end
      endcase

      if (pos_ff != POS_MAX) begin
         pos_in = pos_ff + POS_W'(1);
      end

      // status as seen after this character
      case (kind_in)
         KIND_NMEA: begin
            chk = {24'd0, xor_in};
            if (phase_in == PH_NMEA_BODY) begin
               st = STATUS_NO_STAR;
            end else if (phase_in == PH_NMEA_HEX) begin
               st = (xor_in != hex_in) ? STATUS_MISMATCH : STATUS_OK;
            end else begin
               st = err_in;
            end
         end
         KIND_CRC: begin
            chk = crc_in;
            if (!crc_check_enable) begin
               st = STATUS_OK;
            end else if (phase_in == PH_CRC_BODY) begin
               st = STATUS_NO_STAR;
            end else if (phase_in == PH_CRC_TEXT) begin
               st = STATUS_MISMATCH;
            end else begin
               st = err_in;
            end
         end
         default: begin
            chk = 32'd0;
            st  = STATUS_BAD_START;
         end
      endcase

      out_item_in.status         = st;
      out_item_in.sentence_kind  = kind_in;
      out_item_in.computed_check = chk;

      // final character: back to the line start
      if (stage_item.last) begin
         phase_in = PH_START;
         kind_in  = KIND_UNKNOWN;
         xor_in   = 8'd0;
         crc_in   = 32'd0;
         pos_in   = '0;
         hex_in   = 8'd0;
         dcnt_in  = 4'd0;
         err_in   = STATUS_OK;
      end
   end

   // result slot: drop on take, load on a final character
   always_comb begin
      out_valid_in = out_valid_ff && !out_ready;
      if (stage_take && stage_item.last) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         kind_ff      <= KIND_UNKNOWN;
         xor_ff       <= 8'd0;
         crc_ff       <= 32'd0;
         pos_ff       <= '0;
         hex_ff       <= 8'd0;
         dcnt_ff      <= 4'd0;
         err_ff       <= STATUS_OK;
         out_valid_ff <= 1'b0;
      end else begin
         if (stage_take) begin
            phase_ff <= phase_in;
            kind_ff  <= kind_in;
            xor_ff   <= xor_in;
            crc_ff   <= crc_in;
            pos_ff   <= pos_in;
            hex_ff   <= hex_in;
            dcnt_ff  <= dcnt_in;
            err_ff   <= err_in;
         end
         out_valid_ff <= out_valid_in;
         if (stage_take && stage_item.last) begin
            out_item_ff <= out_item_in;
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;
endmodule

FILE: design/nmea_crc32_sentence_checker.sv
// Top level of the NMEA XOR / CRC-32 sentence checker.
//
//   channel | direction | fields                                   | handshake
//   req_bus | in        | ch[7:0], last                            | valid/ready
//   rsp_bus | out       | status[1:0], sentence_kind[1:0],         | valid/ready
//           |           | computed_check[31:0]                     |
//   csr_*   | in/out    | crc_check_enable at byte address 0       | APB, pready=1
//
// One character per cycle, but a final character waits for a free result slot:
// a transaction is held in the input register, then the XOR / CRC-32 byte update
// writes the state and, on the final character, the result register. Reset
// clears line state, the result slot and the enable.
// A stalled result holds only final characters; others keep flowing.
module nmea_crc32_sentence_checker (
   input  logic                             clock,
   input  logic                             reset,
   ncrc_req_if.sink                         req_bus,
   ncrc_rsp_if.source                       rsp_bus,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ncrc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ncrc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ncrc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import ncrc_pkg::*;

   req_item_type req_item;
   req_item_type stage_item;
   rsp_item_type out_item;
   logic         stage_valid;
   logic         stage_take;
   logic         crc_check_enable;

   assign req_item.ch   = req_bus.ch;
   assign req_item.last = req_bus.last;

   ncrc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready),
      .crc_check_enable (crc_check_enable)
   );

   ncrc_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_bus.valid),
      .in_ready    (req_bus.ready),
      .in_item     (req_item),
      .stage_valid (stage_valid),
      .stage_item  (stage_item),
      .stage_take  (stage_take)
   );

   ncrc_line_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .stage_valid      (stage_valid),
      .stage_item       (stage_item),
      .stage_take       (stage_take),
      .crc_check_enable (crc_check_enable),
      .out_valid        (rsp_bus.valid),
      .out_item         (out_item),
      .out_ready        (rsp_bus.ready)
   );

   assign rsp_bus.status         = out_item.status;
   assign rsp_bus.sentence_kind  = out_item.sentence_kind;
   assign rsp_bus.computed_check = out_item.computed_check;
endmodule

FILE: design/ncrc_checker.sv
// Port-level assertions for the sentence checker, bound to the top level.
module ncrc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [1:0]  rsp_sentence_kind,
   input logic [31:0] rsp_computed_check
);
   import ncrc_pkg::*;

   // a result transaction held back keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_sentence_kind) && $stable(rsp_computed_check))
      else $error("result changed while stalled");

   // a fresh result follows an accepted final character through the input and result registers
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last, 2))
      else $error("result without a final character");

   // kind code three is never produced
   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sentence_kind != 2'd3)
      else $error("invalid sentence kind");

   // bad start reports unknown kind and zero check
   a_bad_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_BAD_START |->
         rsp_sentence_kind == KIND_UNKNOWN && rsp_computed_check == 32'd0)
      else $error("bad start result inconsistent");

   // an XOR check fits in one byte
   a_xor_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sentence_kind == KIND_NMEA |-> rsp_computed_check[31:8] == 24'd0)
      else $error("XOR check wider than a byte");
endmodule

bind nmea_crc32_sentence_checker ncrc_checker u_ncrc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .req_last           (req_bus.last),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_status         (rsp_bus.status),
   .rsp_sentence_kind  (rsp_bus.sentence_kind),
   .rsp_computed_check (rsp_bus.computed_check)
);
